// ===== src/imlp_pkg.sv =====
package imlp_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned NICK_W = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_INVALID    = 2'd2
  } status_t;

  // token kinds
  typedef enum logic [2:0] {
    TK_NONE     = 3'd0,
    TK_PREFIX   = 3'd1,
    TK_COMMAND  = 3'd2,
    TK_PARAM    = 3'd3,
    TK_TRAILING = 3'd4
  } token_t;

  // prefix sub-part while following the nick[!user][@host] path
  typedef enum logic [1:0] {
    PART_NICK = 2'd0,
    PART_USER = 2'd1,
    PART_HOST = 2'd2
  } part_t;

  // register indexes (paddr[2])
  localparam logic REG_NICK_MAX = 1'b0;

  localparam logic [NICK_W-1:0] NICK_MAX_RST = 4'd9;
  localparam logic [NICK_W-1:0] NICK_SAT     = 4'd15;
  localparam logic [1:0]        NUM_DIGITS   = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_spec(input logic [7:0] c);
    return (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7D);
  endfunction

  function automatic logic is_prefix_ch(input logic [7:0] c);
    return is_alpha(c) || is_num(c) || is_spec(c) || c == CH_BANG || c == CH_DOT ||
           c == CH_AT || c == CH_DASH || c == CH_COLON;
  endfunction

  // any octet but NUL, LF, CR, space and colon
  function automatic logic is_pstart(input logic [7:0] c);
    return (c >= 8'h3B) || (c >= 8'h21 && c <= 8'h39) ||
           (c >= 8'h0E && c <= 8'h1F) || (c >= 8'h0B && c <= 8'h0C) ||
           (c >= 8'h01 && c <= 8'h09);
  endfunction

endpackage

// ===== src/irc_message_line_parser.sv =====
// Channel | Dir | Handshake            | Beat contents
// in_     | in  | in_tvalid/in_tready  | tdata: rx_byte; tuser: restart
// out_    | out | out_tvalid/out_tready| tdata: data_byte; tuser: status, kind, flags
// cfg_    | in  | APB psel/penable     | reg 0 @ 0x0: nick_max_len[3:0]
//
// One byte per cycle while in_tready is high. A result beat shows up the cycle after its input beat.
// Parse state updates on the accepting edge, so the next byte sees it at once.
// rst_n is synchronous, active low; it clears parse state and loads nick_max_len = 9.
// in_tready drops only while a result sits in the output register and out_tready is low.
module irc_message_line_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                   in_tuser,   // [0] restart
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] data_byte
  output logic [6:0]                   out_tuser,  // [1:0] status, [4:2] token_kind,
                                                   // [5] byte_in_token, [6] token_end
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [imlp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [imlp_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [imlp_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import imlp_pkg::*;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_PREFIX      = 4'd1,
    PH_CMD_ANY     = 4'd2,
    PH_CMD_NAME    = 4'd3,
    PH_CMD_NUM     = 4'd4,
    PH_PARAM_START = 4'd5,
    PH_PARAM       = 4'd6,
    PH_TRAILING    = 4'd7,
    PH_CR          = 4'd8,
    PH_DONE        = 4'd9
  } phase_t;

  // parse state
  phase_t            phase_r,      phase_nxt;
  logic [1:0]        digit_cnt_r,  digit_cnt_nxt;
  logic              srv_short_r,  srv_short_nxt;   // servername label not yet started
  logic              srv_fail_r,   srv_fail_nxt;
  part_t             part_r,       part_nxt;
  logic [NICK_W-1:0] nick_cnt_r,   nick_cnt_nxt;
  logic              user_open_r,  user_open_nxt;
  logic              user_ne_r,    user_ne_nxt;
  logic              host_open_r,  host_open_nxt;
  logic              host_short_r, host_short_nxt;
  logic              nick_fail_r,  nick_fail_nxt;
  logic              pfx_empty_r,  pfx_empty_nxt;

  logic [NICK_W-1:0] nick_max_r,   nick_max_nxt;

  // output register
  logic              out_valid_r,  out_valid_nxt;
  logic [7:0]        out_byte_r,   out_byte_nxt;
  status_t           out_st_r,     out_st_nxt;
  token_t            out_kind_r,   out_kind_nxt;
  logic              out_inb_r,    out_inb_nxt;
  logic              out_end_r,    out_end_nxt;

  logic              in_fire;
  logic              cfg_wr;
  logic [7:0]        c;
  logic              restart;

  // state seen by this byte (restart clears it first)
  phase_t            cur_phase;
  logic [1:0]        cur_digit;
  logic              cur_srv_short, cur_srv_fail;
  part_t             cur_part;
  logic [NICK_W-1:0] cur_nick;
  logic              cur_user_open, cur_user_ne, cur_host_open, cur_host_short;
  logic              cur_nick_fail, cur_pfx_empty;

  // per-byte results and next state
  status_t           st;
  token_t            kind;
  logic              inb, tend;
  logic              nick_ok, pfx_ok;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_NICK_MAX) ?
                      {{(CFG_DW-NICK_W){1'b0}}, nick_max_r} : '0;

  assign c       = in_tdata;
  assign restart = in_tuser[0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_end_r, out_inb_r, out_kind_r, out_st_r};

  always_comb begin
    if (restart) begin
      cur_phase      = PH_START;
      cur_digit      = '0;
      cur_srv_short  = 1'b1;
      cur_srv_fail   = 1'b0;
      cur_part       = PART_NICK;
      cur_nick       = '0;
      cur_user_open  = 1'b0;
      cur_user_ne    = 1'b0;
      cur_host_open  = 1'b0;
      cur_host_short = 1'b1;
      cur_nick_fail  = 1'b0;
      cur_pfx_empty  = 1'b1;
    end else begin
      cur_phase      = phase_r;
      cur_digit      = digit_cnt_r;
      cur_srv_short  = srv_short_r;
      cur_srv_fail   = srv_fail_r;
      cur_part       = part_r;
      cur_nick       = nick_cnt_r;
      cur_user_open  = user_open_r;
      cur_user_ne    = user_ne_r;
      cur_host_open  = host_open_r;
      cur_host_short = host_short_r;
      cur_nick_fail  = nick_fail_r;
      cur_pfx_empty  = pfx_empty_r;
    end
  end

  // prefix acceptance, evaluated on the closing space
  always_comb begin
    nick_ok = !cur_nick_fail && (cur_nick != '0) && (cur_nick <= nick_max_r);
    if (cur_user_open && !(cur_user_ne && cur_host_open)) begin
      nick_ok = 1'b0;
    end
    if (cur_host_open && cur_host_short) begin
      nick_ok = 1'b0;
    end
    if (cur_pfx_empty) begin
      pfx_ok = 1'b0;
    end else if (!cur_srv_fail && !cur_srv_short) begin
      pfx_ok = 1'b1;
    end else begin
      pfx_ok = nick_ok;
    end
  end

  always_comb begin
    phase_nxt      = cur_phase;
    digit_cnt_nxt  = cur_digit;
    srv_short_nxt  = cur_srv_short;
    srv_fail_nxt   = cur_srv_fail;
    part_nxt       = cur_part;
    nick_cnt_nxt   = cur_nick;
    user_open_nxt  = cur_user_open;
    user_ne_nxt    = cur_user_ne;
    host_open_nxt  = cur_host_open;
    host_short_nxt = cur_host_short;
    nick_fail_nxt  = cur_nick_fail;
    pfx_empty_nxt  = cur_pfx_empty;
    st   = ST_INCOMPLETE;
    kind = TK_NONE;
    inb  = 1'b0;
    tend = 1'b0;

    if (c == CH_NUL) begin
      st = ST_INVALID;
    end else begin
      case (cur_phase)
        PH_START, PH_CMD_ANY: begin
          if (c == CH_COLON && cur_phase == PH_START) begin
            phase_nxt = PH_PREFIX;
            kind      = TK_PREFIX;
          end else if (is_alpha(c)) begin
            phase_nxt = PH_CMD_NAME;
            kind      = TK_COMMAND;
            inb       = 1'b1;
          end else if (is_num(c)) begin
            phase_nxt     = PH_CMD_NUM;
            digit_cnt_nxt = 2'd1;
            kind          = TK_COMMAND;
            inb           = 1'b1;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_PREFIX: begin
          if (is_prefix_ch(c)) begin
            kind          = TK_PREFIX;
            inb           = 1'b1;
            pfx_empty_nxt = 1'b0;
            // servername path
            if (c == CH_BANG || c == CH_AT) begin
              srv_fail_nxt = 1'b1;
            end else if (is_alpha(c) || is_num(c) || (!cur_srv_short && c == CH_DASH)) begin
              srv_short_nxt = 1'b0;
            end else if (c == CH_DOT && !cur_srv_short) begin
              srv_short_nxt = 1'b1;
            end else begin
              srv_fail_nxt = 1'b1;
            end
            // nick[!user][@host] path
            case (cur_part)
              PART_NICK: begin
                if (is_alpha(c) || is_spec(c) ||
                    ((is_num(c) || c == CH_DASH) && cur_nick != '0)) begin
                  if (cur_nick == NICK_SAT) begin
                    nick_fail_nxt = 1'b1;
                  end else begin
                    nick_cnt_nxt = cur_nick + 1'b1;
                  end
                end else if (c == CH_BANG) begin
                  part_nxt      = PART_USER;
                  user_open_nxt = 1'b1;
                end else if (c == CH_AT) begin
                  part_nxt      = PART_HOST;
                  host_open_nxt = 1'b1;
                end else begin
                  nick_fail_nxt = 1'b1;
                end
              end
              PART_USER: begin
                if (c == CH_AT) begin
                  part_nxt      = PART_HOST;
                  host_open_nxt = 1'b1;
                end else begin
                  user_ne_nxt = 1'b1;
                end
              end
              default: begin
                if (is_alpha(c) || is_num(c)) begin
                  host_short_nxt = 1'b0;
                end else if (c == CH_DASH && !cur_host_short) begin
                  host_short_nxt = cur_host_short;
                end else if (c == CH_DOT && !cur_host_short) begin
                  host_short_nxt = 1'b1;
                end else begin
                  nick_fail_nxt = 1'b1;
                end
              end
            endcase
          end else if (c == CH_SPACE && pfx_ok) begin
            phase_nxt = PH_CMD_ANY;
            kind      = TK_PREFIX;
            tend      = 1'b1;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_CMD_NAME: begin
          if (is_alpha(c)) begin
            kind = TK_COMMAND;
            inb  = 1'b1;
          end else if (c == CH_SPACE || c == CH_CR) begin
            phase_nxt = (c == CH_SPACE) ? PH_PARAM_START : PH_CR;
            kind      = TK_COMMAND;
            tend      = 1'b1;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_CMD_NUM: begin
          if ((c == CH_SPACE || c == CH_CR) && cur_digit == NUM_DIGITS) begin
            phase_nxt = (c == CH_SPACE) ? PH_PARAM_START : PH_CR;
            kind      = TK_COMMAND;
            tend      = 1'b1;
          end else if (is_num(c) && cur_digit < NUM_DIGITS) begin
            digit_cnt_nxt = cur_digit + 1'b1;
            kind          = TK_COMMAND;
            inb           = 1'b1;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_PARAM_START: begin
          // LF and space are skipped here
          if (c == CH_COLON) begin
            phase_nxt = PH_TRAILING;
            kind      = TK_TRAILING;
          end else if (c == CH_CR) begin
            phase_nxt = PH_CR;
          end else if (is_pstart(c)) begin
            phase_nxt = PH_PARAM;
            kind      = TK_PARAM;
            inb       = 1'b1;
          end
        end
        PH_PARAM: begin
          if (c == CH_SPACE || c == CH_CR) begin
            phase_nxt = (c == CH_SPACE) ? PH_PARAM_START : PH_CR;
            kind      = TK_PARAM;
            tend      = 1'b1;
          end else if (is_pstart(c) || c == CH_COLON) begin
            kind = TK_PARAM;
            inb  = 1'b1;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_TRAILING: begin
          if (c == CH_CR) begin
            phase_nxt = PH_CR;
            kind      = TK_TRAILING;
            tend      = 1'b1;
          end else if (is_pstart(c) || c == CH_COLON || c == CH_SPACE) begin
            kind = TK_TRAILING;
            inb  = 1'b1;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_CR: begin
          if (c == CH_LF) begin
            phase_nxt = PH_DONE;
            st        = ST_COMPLETE;
          end else begin
            st = ST_INVALID;
          end
        end
        PH_DONE: begin
          st = ST_COMPLETE;
        end
        default: begin
          st = ST_INVALID;
        end
      endcase
    end

    if (st == ST_INVALID) begin
      kind = TK_NONE;
      inb  = 1'b0;
      tend = 1'b0;
    end
  end

  // register inputs of the output stage and the config register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    out_byte_nxt = in_fire ? c    : out_byte_r;
    out_st_nxt   = in_fire ? st   : out_st_r;
    out_kind_nxt = in_fire ? kind : out_kind_r;
    out_inb_nxt  = in_fire ? inb  : out_inb_r;
    out_end_nxt  = in_fire ? tend : out_end_r;
    nick_max_nxt = nick_max_r;
    if (cfg_wr && cfg_paddr[2] == REG_NICK_MAX) begin
      nick_max_nxt = cfg_pwdata[NICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    // payload, no reset
    out_byte_r <= out_byte_nxt;
    out_st_r   <= out_st_nxt;
    out_kind_r <= out_kind_nxt;
    out_inb_r  <= out_inb_nxt;
    out_end_r  <= out_end_nxt;
    if (!rst_n) begin
      phase_r      <= PH_START;
      digit_cnt_r  <= '0;
      srv_short_r  <= 1'b1;
      srv_fail_r   <= 1'b0;
      part_r       <= PART_NICK;
      nick_cnt_r   <= '0;
      user_open_r  <= 1'b0;
      user_ne_r    <= 1'b0;
      host_open_r  <= 1'b0;
      host_short_r <= 1'b1;
      nick_fail_r  <= 1'b0;
      pfx_empty_r  <= 1'b1;
      nick_max_r   <= NICK_MAX_RST;
      out_valid_r  <= 1'b0;
    end else begin
      // rejected bytes leave the parse state as it was (restart still applies)
      if (in_fire) begin
        phase_r      <= phase_nxt;
        digit_cnt_r  <= digit_cnt_nxt;
        srv_short_r  <= srv_short_nxt;
        srv_fail_r   <= srv_fail_nxt;
        part_r       <= part_nxt;
        nick_cnt_r   <= nick_cnt_nxt;
        user_open_r  <= user_open_nxt;
        user_ne_r    <= user_ne_nxt;
        host_open_r  <= host_open_nxt;
        host_short_r <= host_short_nxt;
        nick_fail_r  <= nick_fail_nxt;
        pfx_empty_r  <= pfx_empty_nxt;
      end
      nick_max_r  <= nick_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // NUL beat always comes back invalid
  a_nul_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && c == CH_NUL) |=> (out_st_r == ST_INVALID))
    else $error("NUL byte not reported invalid");

  // once the line is done, any non-NUL byte without restart answers complete
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !restart && phase_r == PH_DONE && c != CH_NUL)
      |=> (out_st_r == ST_COMPLETE))
    else $error("complete did not hold until restart");

  // an invalid byte without restart leaves the phase untouched
  a_invalid_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !restart && st == ST_INVALID) |=> (phase_r == $past(phase_r)))
    else $error("invalid byte changed parse phase");

  // a token end is a delimiter, never token content
  a_end_not_content: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (!out_inb_r && out_kind_r != TK_NONE))
    else $error("token end flagged on content byte");

endmodule
